FILE: rtl/dtq_pkg.sv
// Shared types and constants for the delta-list timer queue.
// No dependencies; every other file in this folder imports it.
package dtq_pkg;

  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned IDX_W       = $clog2(TIMER_SLOTS);

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_ZERO   = 3'd1;
  localparam logic [2:0] STATUS_DUP    = 3'd2;
  localparam logic [2:0] STATUS_FULL   = 3'd3;
  localparam logic [2:0] STATUS_ABSENT = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  timer_slot;
    logic [31:0] tick_count;
    logic [7:0]  task_id;
  } dtq_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       fired;
    logic [3:0] expired_slot;
    logic [7:0] wake_task;
    logic       last;
  } dtq_out_t;

  typedef struct packed {
    logic        vld;
    logic [3:0]  slot;
    logic [31:0] delta;
  } cell_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_LEFT_SUB,
    CELL_FROM_RIGHT,
    CELL_FROM_RIGHT_ADD,
    CELL_DEC
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [3:0]  slot;
    logic [31:0] delta;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_DEC
  } act_e;

endpackage

FILE: rtl/delta_timer_queue.sv
// Delta-list timer queue: a row of cells kept in expiry order and a request sequencer.
// Depends on dtq_pkg and dtq_cell. One request is worked at a time.
// Delete, idle and rejected add are answered from the execute state; an accepted add walks
// past each entry whose delta is within its remaining ticks, then inserts; a tick first
// decrements the head, then reports each expired head. Output stalls hold the results.
// Reset clears all cell valid flags, the queued flags and the control state.
module delta_timer_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtq_pkg::dtq_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dtq_pkg::dtq_out_t out_o
);
  import dtq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_POP  = 2'd3;

  logic [1:0]             state_q, state_d;
  dtq_in_t                req_q;
  logic [IDX_W-1:0]       k_q, k_d;
  logic [31:0]            rem_q, rem_d;
  logic [TIMER_SLOTS-1:0] queued_q, queued_d;
  logic [7:0]             task_mem [TIMER_SLOTS];
  logic                   task_we;
  logic                   out_valid_q, out_valid_d;
  dtq_out_t               out_q, out_d;
  logic                   emit;
  logic                   can_emit;
  act_e                   act;
  logic [IDX_W-1:0]       act_pos;

  cell_t     cells     [TIMER_SLOTS];
  cell_t     left_arr  [TIMER_SLOTS];
  cell_t     right_arr [TIMER_SLOTS];
  cell_cmd_t cmds      [TIMER_SLOTS];

  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] head_idx;
  logic             slot_ok;
  logic [IDX_W-1:0] hit_pos;
  logic             hit_found;
  cell_t            cur_cell;
  logic             head_fires;
  logic             next_fires;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cells
    if (g == 0) begin : g_first
      assign left_arr[g] = '0;
    end else begin : g_mid_l
      assign left_arr[g] = cells[g-1];
    end
    if (g == TIMER_SLOTS - 1) begin : g_last
      assign right_arr[g] = '0;
    end else begin : g_mid_r
      assign right_arr[g] = cells[g+1];
    end
    dtq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmds[g]),
      .left_i  (left_arr[g]),
      .right_i (right_arr[g]),
      .cell_o  (cells[g])
    );
  end

  assign slot_idx   = IDX_W'(req_q.timer_slot);
  assign head_idx   = IDX_W'(cells[0].slot);
  assign slot_ok    = (32'(req_q.timer_slot) < TIMER_SLOTS);
  assign cur_cell   = cells[k_q];
  assign head_fires = cells[0].vld && (cells[0].delta == '0);
  assign next_fires = cells[1].vld && (cells[1].delta == '0);
  assign can_emit   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    hit_found = 1'b0;
    hit_pos   = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (!hit_found && cells[i].vld && (cells[i].slot == req_q.timer_slot)) begin
        hit_found = 1'b1;
        hit_pos   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      cmds[i].slot  = req_q.timer_slot;
      cmds[i].delta = rem_q;
      cmds[i].op    = CELL_HOLD;
      unique case (act)
        ACT_INSERT: begin
          if ((IDX_W+1)'(i) == {1'b0, act_pos}) begin
            cmds[i].op = CELL_LOAD;
          end else if ((IDX_W+1)'(i) == {1'b0, act_pos} + 1'b1) begin
            cmds[i].op = CELL_FROM_LEFT_SUB;
          end else if ((IDX_W+1)'(i) > {1'b0, act_pos}) begin
            cmds[i].op = CELL_FROM_LEFT;
          end
        end
        ACT_REMOVE: begin
          if ((IDX_W+1)'(i) == {1'b0, act_pos}) begin
            cmds[i].op = CELL_FROM_RIGHT_ADD;
          end else if ((IDX_W+1)'(i) > {1'b0, act_pos}) begin
            cmds[i].op = CELL_FROM_RIGHT;
          end
        end
        ACT_DEC: begin
          if (i == 0) begin
            cmds[i].op = CELL_DEC;
          end
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    rem_d    = rem_q;
    queued_d = queued_q;
    task_we  = 1'b0;
    emit     = 1'b0;
    out_d    = '0;
    act      = ACT_NONE;
    act_pos  = '0;
    out_d.status = STATUS_OK;
    out_d.last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_q.req_type)
          REQ_ADD: begin
            priority if (req_q.tick_count == '0) begin
              out_d.status = STATUS_ZERO;
              emit         = can_emit;
            end else if (!slot_ok) begin
              out_d.status = STATUS_ABSENT;
              emit         = can_emit;
            end else if (queued_q[slot_idx]) begin
              out_d.status = STATUS_DUP;
              emit         = can_emit;
            end else if (cells[TIMER_SLOTS-1].vld) begin
              out_d.status = STATUS_FULL;
              emit         = can_emit;
            end else begin
              state_d = ST_WALK;
              k_d     = '0;
              rem_d   = req_q.tick_count;
            end
            if (emit) begin
              state_d = ST_IDLE;
            end
          end
          REQ_DEL: begin
            if (can_emit) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
              if (!slot_ok || !queued_q[slot_idx]) begin
                out_d.status = STATUS_ABSENT;
              end else begin
                queued_d[slot_idx] = 1'b0;
                if (hit_found) begin
                  act     = ACT_REMOVE;
                  act_pos = hit_pos;
                end
              end
            end
          end
          REQ_TICK: begin
            act     = ACT_DEC;
            state_d = ST_POP;
          end
          default: begin
            if (can_emit) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_WALK: begin
        if (cur_cell.vld && (rem_q >= cur_cell.delta)) begin
          rem_d = rem_q - cur_cell.delta;
          k_d   = k_q + 1'b1;
        end else if (can_emit) begin
          act                = ACT_INSERT;
          act_pos            = k_q;
          task_we            = 1'b1;
          queued_d[slot_idx] = 1'b1;
          emit               = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_POP: begin
        if (can_emit) begin
          emit = 1'b1;
          if (head_fires) begin
            out_d.fired        = 1'b1;
            out_d.expired_slot = cells[0].slot;
            out_d.wake_task    = task_mem[head_idx];
            out_d.last         = !next_fires;
            queued_d[head_idx] = 1'b0;
            act                = ACT_REMOVE;
            act_pos            = '0;
            if (!next_fires) begin
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      queued_q    <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      queued_q    <= queued_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
    if (task_we) begin
      task_mem[slot_idx] <= req_q.task_id;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/dtq_cell.sv
// One queue position of the delta list: valid flag, slot and relative delay.
// Depends on dtq_pkg for the cell and command types.
module dtq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtq_pkg::cell_cmd_t cmd_i,
  input  dtq_pkg::cell_t    left_i,
  input  dtq_pkg::cell_t    right_i,
  output dtq_pkg::cell_t    cell_o
);
  import dtq_pkg::*;

  cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    unique case (cmd_i.op)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        cell_d.vld   = 1'b1;
        cell_d.slot  = cmd_i.slot;
        cell_d.delta = cmd_i.delta;
      end
      CELL_FROM_LEFT: begin
        cell_d = left_i;
      end
      CELL_FROM_LEFT_SUB: begin
        cell_d       = left_i;
        cell_d.delta = left_i.delta - cmd_i.delta;
      end
      CELL_FROM_RIGHT: begin
        cell_d = right_i;
      end
      CELL_FROM_RIGHT_ADD: begin
        cell_d       = right_i;
        cell_d.delta = right_i.delta + cell_q.delta;
      end
      CELL_DEC: begin
        if (cell_q.delta != '0) begin
          cell_d.delta = cell_q.delta - 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: rtl/dtq_checker.sv
// Port-level checks for the delta-list timer queue and the bind that attaches them.
// Depends on dtq_pkg and on the ports of delta_timer_queue.
module dtq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dtq_pkg::dtq_in_t  in_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dtq_pkg::dtq_out_t out_o
);
  import dtq_pkg::*;

  // A result waiting for its transfer keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // The block works one request at a time, so it is busy right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // A result that reports no expiry always ends its request and carries no timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.fired |->
      out_o.last && (out_o.expired_slot == '0) && (out_o.wake_task == '0))
    else $error("non-fired result malformed");

  // Expired timers are only reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.fired |-> out_o.status == STATUS_OK)
    else $error("fired result with error status");

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (.*);

FILE: tb/delta_timer_queue_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the delta-list timer queue: a queue-fed driver, a monitor
// and an in-bench model of the expiry list that predicts every result. Depends on dtq_pkg.
module delta_timer_queue_test;
  import dtq_pkg::*;

  localparam logic [1:0] REQ_IDLE = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 410;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dtq_in_t  in_d = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dtq_out_t out_d;

  dtq_in_t  pending_reqs[$];
  dtq_out_t due_results[$];
  dtq_out_t want;
  int       n_errors = 0;
  int       n_in = 0;
  int       idle_cycles = 0;
  logic     quiet;

  logic [3:0]  ord_slot[TIMER_SLOTS];
  logic [31:0] ord_delta[TIMER_SLOTS];
  logic [7:0]  task_of[TIMER_SLOTS];
  bit          queued[TIMER_SLOTS];
  int unsigned depth = 0;

  delta_timer_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_d),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_d)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  assign quiet = (n_in >= 120) && (n_in < 240);

  function automatic dtq_out_t make_result(logic [2:0] st, logic fired, logic [3:0] slot,
                                           logic [7:0] tid, logic last);
    dtq_out_t r;
    r.status = st;
    r.fired = fired;
    r.expired_slot = slot;
    r.wake_task = tid;
    r.last = last;
    return r;
  endfunction

  // Removes one list position; its delta carries over to the entry behind it.
  function automatic void unlink_entry(int unsigned p);
    int unsigned i;
    if (p + 1 < depth) ord_delta[p + 1] = ord_delta[p + 1] + ord_delta[p];
    queued[ord_slot[p]] = 1'b0;
    for (i = p; i + 1 < depth; i++) begin
      ord_slot[i] = ord_slot[i + 1];
      ord_delta[i] = ord_delta[i + 1];
    end
    depth--;
  endfunction

  function automatic logic [2:0] insert_timer(logic [3:0] slot, logic [31:0] ticks,
                                              logic [7:0] tid);
    logic [31:0] rem;
    int unsigned p;
    int unsigned i;
    rem = ticks;
    p = 0;
    if (ticks == 32'd0) return STATUS_ZERO;
    if (int'(slot) >= TIMER_SLOTS) return STATUS_ABSENT;
    if (queued[slot]) return STATUS_DUP;
    if (depth >= TIMER_SLOTS) return STATUS_FULL;
    while (p < depth) begin
      if (rem < ord_delta[p]) begin
        ord_delta[p] = ord_delta[p] - rem;
        break;
      end
      rem = rem - ord_delta[p];
      p++;
    end
    for (i = depth; i > p; i--) begin
      ord_slot[i] = ord_slot[i - 1];
      ord_delta[i] = ord_delta[i - 1];
    end
    ord_slot[p] = slot;
    ord_delta[p] = rem;
    task_of[slot] = tid;
    queued[slot] = 1'b1;
    depth++;
    return STATUS_OK;
  endfunction

  function automatic logic [2:0] delete_timer(logic [3:0] slot);
    int unsigned p;
    if (int'(slot) >= TIMER_SLOTS || !queued[slot]) return STATUS_ABSENT;
    for (p = 0; p < depth; p++) begin
      if (ord_slot[p] == slot) begin
        unlink_entry(p);
        return STATUS_OK;
      end
    end
    queued[slot] = 1'b0;
    return STATUS_OK;
  endfunction

  function automatic void tick_expiries();
    dtq_out_t held;
    int       n;
    n = 0;
    held = '0;
    if (depth > 0 && ord_delta[0] > 0) ord_delta[0] = ord_delta[0] - 32'd1;
    while (depth > 0 && ord_delta[0] == 32'd0 && n < 16) begin
      if (n > 0) due_results.push_back(held);
      held = make_result(STATUS_OK, 1'b1, ord_slot[0], task_of[ord_slot[0]], 1'b0);
      unlink_entry(0);
      n++;
    end
    if (n == 0) begin
      due_results.push_back(make_result(STATUS_OK, 1'b0, 4'd0, 8'd0, 1'b1));
    end else begin
      held.last = 1'b1;
      due_results.push_back(held);
    end
  endfunction

  function automatic void apply_request(dtq_in_t r);
    logic [2:0] st;
    st = STATUS_OK;
    case (r.req_type)
      REQ_TICK: begin
        tick_expiries();
        return;
      end
      REQ_ADD: st = insert_timer(r.timer_slot, r.tick_count, r.task_id);
      REQ_DEL: st = delete_timer(r.timer_slot);
      default: st = STATUS_OK;
    endcase
    due_results.push_back(make_result(st, 1'b0, 4'd0, 8'd0, 1'b1));
  endfunction

  task automatic push_req(input logic [1:0] kind, input int slot, input logic [31:0] ticks,
                          input int tid);
    dtq_in_t r;
    r.req_type = kind;
    r.timer_slot = slot[3:0];
    r.tick_count = ticks;
    r.task_id = tid[7:0];
    pending_reqs.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_d <= '0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_d);
        n_in <= n_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
          in_d <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result st=%0d fired=%0d slot=%0d task=%0d last=%0d",
                   $time, out_d.status, out_d.fired, out_d.expired_slot, out_d.wake_task,
                   out_d.last);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          if (out_d.status !== want.status || out_d.fired !== want.fired ||
              out_d.expired_slot !== want.expired_slot || out_d.wake_task !== want.wake_task ||
              out_d.last !== want.last) begin
            $display("%0t: expected st=%0d fired=%0d slot=%0d task=%0d last=%0d",
                     $time, want.status, want.fired, want.expired_slot, want.wake_task,
                     want.last);
            $display("%0t: got      st=%0d fired=%0d slot=%0d task=%0d last=%0d",
                     $time, out_d.status, out_d.fired, out_d.expired_slot, out_d.wake_task,
                     out_d.last);
            n_errors++;
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n_gen;
    int pick;
    int s;
    logic [31:0] ticks;

    n_gen = 0;
    // Error statuses, an empty tick, equal expiries, head removal and a multi-timer expiry.
    push_req(REQ_ADD, 0, 32'd0, 8'h5A);
    push_req(REQ_TICK, 0, 32'd0, 0);
    push_req(REQ_DEL, 5, 32'd0, 0);
    push_req(REQ_IDLE, 15, 32'hFFFF_FFFF, 8'hFF);
    push_req(REQ_ADD, 1, 32'd3, 8'hFF);
    push_req(REQ_ADD, 2, 32'd3, 8'h01);
    push_req(REQ_ADD, 3, 32'd1, 8'h80);
    push_req(REQ_ADD, 1, 32'd7, 8'h11);
    push_req(REQ_ADD, 4, 32'hFFFF_FFFF, 8'h00);
    push_req(REQ_ADD, 15, 32'd2, 8'h7E);
    push_req(REQ_DEL, 3, 32'd0, 0);
    push_req(REQ_TICK, 0, 32'd0, 0);
    push_req(REQ_TICK, 0, 32'd0, 0);
    push_req(REQ_TICK, 0, 32'd0, 0);
    push_req(REQ_DEL, 4, 32'd0, 0);
    push_req(REQ_DEL, 4, 32'd0, 0);
    push_req(REQ_TICK, 0, 32'd0, 0);

    while (n_gen < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        // Clear and load every slot so that one of the two ticks expires the whole list.
        ticks = $urandom_range(2, 1);
        for (s = 0; s < TIMER_SLOTS; s++) push_req(REQ_DEL, s, $urandom(), $urandom_range(255));
        for (s = 0; s < TIMER_SLOTS; s++) push_req(REQ_ADD, s, ticks, $urandom_range(255));
        push_req(REQ_TICK, $urandom_range(15), $urandom(), $urandom_range(255));
        push_req(REQ_TICK, $urandom_range(15), $urandom(), $urandom_range(255));
        n_gen += 2 * TIMER_SLOTS + 2;
      end else if (pick < 45) begin
        pick = $urandom_range(99);
        if (pick < 5) ticks = 32'd0;
        else if (pick < 12) ticks = $urandom();
        else if (pick < 15) ticks = 32'hFFFF_FFFF;
        else ticks = $urandom_range(10, 1);
        push_req(REQ_ADD, $urandom_range(15), ticks, $urandom_range(255));
        n_gen++;
      end else if (pick < 78) begin
        push_req(REQ_TICK, $urandom_range(15), $urandom(), $urandom_range(255));
        n_gen++;
      end else if (pick < 95) begin
        push_req(REQ_DEL, $urandom_range(15), $urandom(), $urandom_range(255));
        n_gen++;
      end else begin
        push_req(REQ_IDLE, $urandom_range(15), $urandom(), $urandom_range(255));
        n_gen++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid || due_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
